>>> rtl/cfs_pkg.sv
// Shared constants for the CNF formula confusion scorer: operation codes and stream packing.
`default_nettype none

package cfs_pkg;

	// Operation codes carried on the input tuser.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_SCORE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Field widths of the request and result items.
	localparam int OP_W     = 2;
	localparam int IDX_W    = 4;
	localparam int MASK_W   = 64;
	localparam int CCOUNT_W = 5;
	localparam int OUT_CW   = 32;

	// Input tdata layout, lowest bit first.
	localparam int IDX_LSB      = 0;
	localparam int POS_LSB      = IDX_LSB + IDX_W;
	localparam int NEG_LSB      = POS_LSB + MASK_W;
	localparam int ROW_LSB      = NEG_LSB + MASK_W;
	localparam int GOAL_BIT     = ROW_LSB + MASK_W;
	localparam int IN_FIELDS_W  = GOAL_BIT + 1;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

	// Output tdata layout, lowest bit first.
	localparam int SAT_BIT      = 0;
	localparam int ACC_BIT      = 1;
	localparam int TP_LSB       = 2;
	localparam int FN_LSB       = TP_LSB + OUT_CW;
	localparam int FP_LSB       = FN_LSB + OUT_CW;
	localparam int TN_LSB       = FP_LSB + OUT_CW;
	localparam int OUT_FIELDS_W = TN_LSB + OUT_CW;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage : cfs_pkg

`default_nettype wire

>>> rtl/cnf_formula_confusion_scorer.sv
// Top level of the CNF formula confusion scorer: clause table, evaluation, counters, ratio test.
`default_nettype none

// Scores data rows against a CNF formula held in an on-chip clause table and keeps four
// saturating confusion counters (TP, FN, FP, TN). Each request is a load of one clause, a
// row to score, or a counter clear (tuser selects which); every request gives exactly one
// result with the formula outcome, the accuracy test flag and the four counters after the
// request. The block takes one request per clock while the output is not stalled. In order,
// an input stage evaluates all clauses in parallel and updates the counters, a second stage
// forms the right and wrong sums and the ratio compare, and a result register drives the
// output stream. Backpressure on the output stalls only as far as needed; empty stages keep
// accepting. The clause table and counters clear at reset.
// clause_count may only be written while no request is in flight.
module cnf_formula_confusion_scorer #(
	parameter int MAX_CLAUSES = 16,
	parameter int ROW_WIDTH   = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration write: clause_count.
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [cfs_pkg::CCOUNT_W-1:0]    cfg_data,
	// Request stream.
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: clause_index[3:0], pos_mask[67:4], neg_mask[131:68], row_bits[195:132],
	// goal[196], zero fill [199:197]
	input  wire logic [cfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: operation[1:0]
	input  wire logic [cfs_pkg::OP_W-1:0]        s_axis_tuser,
	// Result stream.
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// tdata: satisfied[0], accept[1], tp_count[33:2], fn_count[65:34], fp_count[97:66],
	// tn_count[129:98], zero fill [135:130]
	output logic [cfs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int SUM_W = COUNT_WIDTH + 3;

	// Configuration register.
	logic [cfs_pkg::CCOUNT_W-1:0] clause_count_q;

	// Stage 1 registers.
	logic                         valid_s1;
	logic [cfs_pkg::OP_W-1:0]     op_s1;
	logic [cfs_pkg::IDX_W-1:0]    idx_s1;
	logic [ROW_WIDTH-1:0]         pos_s1;
	logic [ROW_WIDTH-1:0]         neg_s1;
	logic [ROW_WIDTH-1:0]         row_s1;
	logic                         goal_s1;

	// Clause table.
	logic [ROW_WIDTH-1:0]         pos_tbl_q [MAX_CLAUSES];
	logic [ROW_WIDTH-1:0]         neg_tbl_q [MAX_CLAUSES];
	logic [MAX_CLAUSES-1:0]       clause_ok;
	logic                         sat;

	// Counters.
	logic [COUNT_WIDTH-1:0]       tp_q, fn_q, fp_q, tn_q;
	logic [COUNT_WIDTH-1:0]       tp_nxt, fn_nxt, fp_nxt, tn_nxt;

	// Stage 2 registers.
	logic                         valid_s2;
	logic [cfs_pkg::OP_W-1:0]     op_s2;
	logic                         sat_s2;
	logic [COUNT_WIDTH-1:0]       tp_s2, fn_s2, fp_s2, tn_s2;
	logic [SUM_W-1:0]             right_sum;
	logic [SUM_W-1:0]             wrong_sum;
	logic [SUM_W-1:0]             wrong_x3;
	logic                         accept;

	// Result register.
	logic                         out_valid_q;
	logic [cfs_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic [cfs_pkg::OUT_TDATA_W-1:0] out_word;

	// Handshake chain.
	logic                         out_ready;
	logic                         s2_ready;
	logic                         s1_ready;
	logic                         s1_fire;
	logic                         s2_fire;

	assign out_ready     = !out_valid_q || m_axis_tready;
	assign s2_ready      = !valid_s2 || out_ready;
	assign s1_ready      = !valid_s1 || s2_ready;
	assign s1_fire       = valid_s1 && s2_ready;
	assign s2_fire       = valid_s2 && out_ready;
	assign s_axis_tready = s1_ready;
	assign cfg_ready     = 1'b1;

	// Configuration register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clause_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			clause_count_q <= cfg_data;
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Stage 1 payload capture.
	always_ff @(posedge clk) begin
		if (s1_ready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			idx_s1  <= s_axis_tdata[cfs_pkg::IDX_LSB +: cfs_pkg::IDX_W];
			pos_s1  <= s_axis_tdata[cfs_pkg::POS_LSB +: ROW_WIDTH];
			neg_s1  <= s_axis_tdata[cfs_pkg::NEG_LSB +: ROW_WIDTH];
			row_s1  <= s_axis_tdata[cfs_pkg::ROW_LSB +: ROW_WIDTH];
			goal_s1 <= s_axis_tdata[cfs_pkg::GOAL_BIT];
		end
	end

	// One lane per clause: table entry write and clause evaluation.
	// An unused entry passes; an index beyond the table matches no lane.
	for (genvar k = 0; k < MAX_CLAUSES; k++) begin : g_clause
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_tbl_q[k] <= '0;
				neg_tbl_q[k] <= '0;
			end else if (s1_fire && op_s1 == cfs_pkg::OP_LOAD && int'(idx_s1) == k) begin
				pos_tbl_q[k] <= pos_s1;
				neg_tbl_q[k] <= neg_s1;
			end
		end

		assign clause_ok[k] = (int'(clause_count_q) <= k) ||
			(|((pos_tbl_q[k] & row_s1) | (neg_tbl_q[k] & ~row_s1)));
	end

	assign sat = (op_s1 == cfs_pkg::OP_SCORE) && (&clause_ok);

	// Next counter values for the request in stage 1.
	always_comb begin
		tp_nxt = tp_q;
		fn_nxt = fn_q;
		fp_nxt = fp_q;
		tn_nxt = tn_q;
		unique case (op_s1)
			cfs_pkg::OP_SCORE: begin
				priority if (sat && goal_s1) begin
					if (tp_q != '1) tp_nxt = tp_q + COUNT_WIDTH'(1);
				end else if (!sat && goal_s1) begin
					if (fn_q != '1) fn_nxt = fn_q + COUNT_WIDTH'(1);
				end else if (!sat && !goal_s1) begin
					if (tn_q != '1) tn_nxt = tn_q + COUNT_WIDTH'(1);
				end else begin
					if (fp_q != '1) fp_nxt = fp_q + COUNT_WIDTH'(1);
				end
			end
			cfs_pkg::OP_CLEAR: begin
				tp_nxt = '0;
				fn_nxt = '0;
				fp_nxt = '0;
				tn_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	// Counter registers advance as a request leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q <= '0;
			fn_q <= '0;
			fp_q <= '0;
			tn_q <= '0;
		end else if (s1_fire) begin
			tp_q <= tp_nxt;
			fn_q <= fn_nxt;
			fp_q <= fp_nxt;
			tn_q <= tn_nxt;
		end
	end

	// Stage 2 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload: outcome and a snapshot of the updated counters.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			op_s2  <= op_s1;
			sat_s2 <= sat;
			tp_s2  <= tp_nxt;
			fn_s2  <= fn_nxt;
			fp_s2  <= fp_nxt;
			tn_s2  <= tn_nxt;
		end
	end

	// Ratio test: no errors, or right >= 3 * wrong.
	assign right_sum = SUM_W'(tp_s2) + SUM_W'(tn_s2);
	assign wrong_sum = SUM_W'(fp_s2) + SUM_W'(fn_s2);
	assign wrong_x3  = (wrong_sum << 1) + wrong_sum;
	assign accept    = (wrong_sum == '0) || (right_sum >= wrong_x3);

	// Packed result word.
	always_comb begin
		out_word = '0;
		out_word[cfs_pkg::SAT_BIT] = sat_s2;
		out_word[cfs_pkg::ACC_BIT] = accept;
		out_word[cfs_pkg::TP_LSB +: cfs_pkg::OUT_CW] = cfs_pkg::OUT_CW'(tp_s2);
		out_word[cfs_pkg::FN_LSB +: cfs_pkg::OUT_CW] = cfs_pkg::OUT_CW'(fn_s2);
		out_word[cfs_pkg::FP_LSB +: cfs_pkg::OUT_CW] = cfs_pkg::OUT_CW'(fp_s2);
		out_word[cfs_pkg::TN_LSB +: cfs_pkg::OUT_CW] = cfs_pkg::OUT_CW'(tn_s2);
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			out_data_q <= out_word;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
	// Only a scored row may report a satisfied formula.
	a_sat_only_score: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && op_s2 != cfs_pkg::OP_SCORE) |-> !sat_s2)
		else $error("satisfied set on a non-score request");

	// Counters never fall except on a clear.
	a_counts_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && op_s1 != cfs_pkg::OP_CLEAR) |=>
		(tp_q >= $past(tp_q) && fn_q >= $past(fn_q) &&
		 fp_q >= $past(fp_q) && tn_q >= $past(tn_q)))
		else $error("confusion counter decreased without a clear");

	// The input is refused only while stage 1 holds a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1)
		else $error("input stalled with an empty first stage");

	// A clear always yields a passing ratio test.
	a_clear_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_fire && op_s2 == cfs_pkg::OP_CLEAR) |=> m_axis_tdata[cfs_pkg::ACC_BIT])
		else $error("accept flag low after a counter clear");
`endif

endmodule : cnf_formula_confusion_scorer

`default_nettype wire
